[sv/vlas_pkg.sv]
`default_nettype none
// Shared types, constants and helper functions for the vector lane add/sub unit.
// Used by vlas_lane and by the top level vector_lane_add_sub_unit; no dependencies.
package vlas_pkg;

    // Field layout: eight 16-bit lanes, four lanes per 64-bit half.
    localparam int unsigned FIELD_LANES = 8;
    localparam int unsigned LANE_W      = 16;
    localparam int unsigned VEC_W       = FIELD_LANES * LANE_W;
    localparam int unsigned ACTION_W    = 3;

    // Stream payload widths.
    localparam int unsigned IN_DATA_W   = 2 * VEC_W;
    localparam int unsigned OUT_DATA_W  = 2 * VEC_W + 2 * FIELD_LANES;

    typedef logic [ACTION_W-1:0] action_t;
    typedef logic [LANE_W-1:0]   lane_t;

    // Operation codes.
    localparam action_t ACT_ADD_CLAMP = 3'd0;
    localparam action_t ACT_SUB_CLAMP = 3'd1;
    localparam action_t ACT_ABS       = 3'd2;
    localparam action_t ACT_ADD_CARRY = 3'd3;
    localparam action_t ACT_SUB_BORROW = 3'd4;

    // Signed 16-bit limits.
    localparam lane_t LANE_MAX = 16'h7FFF;
    localparam lane_t LANE_MIN = 16'h8000;

    // Everything one lane produces for one item.
    typedef struct packed {
        lane_t vd;
        lane_t acc;
        logic  carry;
        logic  not_equal;
    } lane_result_t;

    // Clamp an 18-bit signed value to the signed 16-bit range.
    function automatic lane_t clamp16(input logic signed [17:0] v);
        lane_t res;
        if (v > 18'sd32767) begin
            res = LANE_MAX;
        end
        else if (v < -18'sd32768) begin
            res = LANE_MIN;
        end
        else begin
            res = v[15:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

[sv/vector_lane_add_sub_unit.sv]
`default_nettype none
// Top level of the vector lane add/sub unit: input register, eight lane
// datapaths, flag and accumulator state, and result register. Depends on
// vlas_pkg and vlas_lane.
//
//  Channel  Direction  Payload
//  -------  ---------  ------------------------------------------------------
//  s_axis   in         tuser: action; tdata: vs lanes 0-7, vt lanes 0-7
//  m_axis   out        tdata: vd lanes 0-7, acc lanes 0-7, carry, not-equal
//
// Every item passes through the input register, where the lane datapaths
// and the flag state meet, and then through the result register, from which
// its result is taken. A new item is accepted every cycle as long as the
// result register drains. The carry, not-equal and accumulator state is
// updated at the same edge that moves an item into the result register, so
// the next item already sees it.
// Reset clears both valid bits and all state.
// When m_axis stalls with a result held, one more item can wait in the input
// register; after that s_axis_tready drops until the result is taken.
module vector_lane_add_sub_unit #(
    parameter int unsigned LANES = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // Fields from bit 0 up: vs_first_half, vs_second_half, vt_first_half,
    // vt_second_half (64 bits each).
    input  logic [vlas_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // Fields from bit 0 up: action (3 bits).
    input  vlas_pkg::action_t                   s_axis_tuser,

    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // Fields from bit 0 up: vd_first_half, vd_second_half, acc_first_half,
    // acc_second_half (64 bits each), carry_out_flags, not_equal_out_flags
    // (8 bits each).
    output logic [vlas_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
    import vlas_pkg::*;

    // Lanes at or above this count are not computed and keep their accumulator.
    localparam int unsigned ACT_LANES = (LANES > FIELD_LANES) ? FIELD_LANES : LANES;

    // Input register.
    logic                   in_valid_reg;
    action_t                in_action_reg;
    logic [VEC_W-1:0]       in_vs_reg;
    logic [VEC_W-1:0]       in_vt_reg;

    // Result register.
    logic                   out_valid_reg;
    logic [OUT_DATA_W-1:0]  out_data_reg;
    logic [OUT_DATA_W-1:0]  out_data_next;

    // Architectural state.
    logic [FIELD_LANES-1:0] carry_reg;
    logic [FIELD_LANES-1:0] carry_next;
    logic [FIELD_LANES-1:0] not_equal_reg;
    logic [FIELD_LANES-1:0] not_equal_next;
    lane_t                  acc_reg  [FIELD_LANES];
    lane_t                  acc_next [FIELD_LANES];

    logic [VEC_W-1:0]       vd_vec;
    logic [VEC_W-1:0]       acc_vec;
    logic                   advance;

    // The item in the input register moves on whenever the result register
    // is empty or being emptied.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    genvar gi;
    generate
        for (gi = 0; gi < FIELD_LANES; gi = gi + 1) begin : g_lane
            if (gi < ACT_LANES) begin : g_active
                lane_result_t res;

                vlas_lane u_lane (
                    .action       (in_action_reg),
                    .vs           (in_vs_reg[gi*LANE_W +: LANE_W]),
                    .vt           (in_vt_reg[gi*LANE_W +: LANE_W]),
                    .acc_in       (acc_reg[gi]),
                    .carry_in     (carry_reg[gi]),
                    .not_equal_in (not_equal_reg[gi]),
                    .result       (res)
                );

                assign vd_vec[gi*LANE_W +: LANE_W] = res.vd;
                assign acc_next[gi]                = res.acc;
                assign carry_next[gi]              = res.carry;
                assign not_equal_next[gi]          = res.not_equal;
            end
            else begin : g_idle
                // The clamping add and subtract clear the whole flag sets,
                // including lanes that are not computed.
                assign vd_vec[gi*LANE_W +: LANE_W] = '0;
                assign acc_next[gi]                = acc_reg[gi];
                assign carry_next[gi]              =
                    ((in_action_reg == ACT_ADD_CLAMP) || (in_action_reg == ACT_SUB_CLAMP))
                    ? 1'b0 : carry_reg[gi];
                assign not_equal_next[gi]          =
                    ((in_action_reg == ACT_ADD_CLAMP) || (in_action_reg == ACT_SUB_CLAMP))
                    ? 1'b0 : not_equal_reg[gi];
            end
            assign acc_vec[gi*LANE_W +: LANE_W] = acc_next[gi];
        end
    endgenerate

    assign out_data_next = {not_equal_next, carry_next, acc_vec, vd_vec};

    // Handshake control and flag/accumulator state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            carry_reg     <= '0;
            not_equal_reg <= '0;
            for (int i = 0; i < FIELD_LANES; i++) begin
                acc_reg[i] <= '0;
            end
        end
        else begin
            if (s_axis_tready) begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                carry_reg     <= carry_next;
                not_equal_reg <= not_equal_next;
                for (int i = 0; i < FIELD_LANES; i++) begin
                    acc_reg[i] <= acc_next[i];
                end
            end
            else if (m_axis_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_action_reg <= s_axis_tuser;
            in_vs_reg     <= s_axis_tdata[VEC_W-1:0];
            in_vt_reg     <= s_axis_tdata[IN_DATA_W-1:VEC_W];
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
`default_nettype wire

[sv/vlas_lane.sv]
`default_nettype none
// One lane of the add/sub unit: computes the destination element, the new
// accumulator slice and the new lane flags. Depends on vlas_pkg.
module vlas_lane (
    input  vlas_pkg::action_t      action,
    input  vlas_pkg::lane_t        vs,
    input  vlas_pkg::lane_t        vt,
    input  vlas_pkg::lane_t        acc_in,
    input  logic                   carry_in,
    input  logic                   not_equal_in,
    output vlas_pkg::lane_result_t result
);
    import vlas_pkg::*;

    logic signed [17:0] s_ext;
    logic signed [17:0] t_ext;
    logic signed [17:0] c_ext;
    logic signed [17:0] add_wide;
    logic signed [17:0] sub_wide;
    logic [16:0]        u_sum;
    logic [16:0]        u_diff;
    lane_t              abs_raw;
    lane_t              abs_val;

    assign s_ext = {{2{vs[15]}}, vs};
    assign t_ext = {{2{vt[15]}}, vt};
    assign c_ext = {17'd0, carry_in};

    assign add_wide = s_ext + t_ext + c_ext;
    assign sub_wide = s_ext - t_ext - c_ext;

    assign u_sum  = {1'b0, vs} + {1'b0, vt};
    assign u_diff = {1'b0, vs} - {1'b0, vt};

    // VT times the sign of VS; a result equal to LANE_MIN saturates to LANE_MAX.
    always_comb
    begin
        if (vs[15]) begin
            abs_raw = 16'd0 - vt;
        end
        else if (vs == 16'd0) begin
            abs_raw = 16'd0;
        end
        else begin
            abs_raw = vt;
        end
        abs_val = (abs_raw == LANE_MIN) ? LANE_MAX : abs_raw;
    end

    always_comb
    begin
        result.vd        = 16'd0;
        result.acc       = acc_in;
        result.carry     = carry_in;
        result.not_equal = not_equal_in;
        case (action)
            ACT_ADD_CLAMP: begin
                result.vd        = clamp16(add_wide);
                result.acc       = add_wide[15:0];
                result.carry     = 1'b0;
                result.not_equal = 1'b0;
            end
            ACT_SUB_CLAMP: begin
                result.vd        = clamp16(sub_wide);
                result.acc       = sub_wide[15:0];
                result.carry     = 1'b0;
                result.not_equal = 1'b0;
            end
            ACT_ABS: begin
                result.vd  = abs_val;
                result.acc = abs_val;
            end
            ACT_ADD_CARRY: begin
                result.vd        = u_sum[15:0];
                result.acc       = u_sum[15:0];
                result.carry     = u_sum[16];
                result.not_equal = 1'b0;
            end
            ACT_SUB_BORROW: begin
                result.vd        = u_diff[15:0];
                result.acc       = u_diff[15:0];
                result.carry     = u_diff[16];
                result.not_equal = (vs != vt);
            end
            default: begin
                // Undefined operation: no change, destination reads zero.
                result.vd = 16'd0;
            end
        endcase
    end

endmodule
`default_nettype wire
